// ===== sv/pas_pkg.sv =====
// ----------------------------------------------------------------------------
// pas_pkg: shared types and codes for the priority aging scheduler
// Ready-table entry layout, command and status codes, shared-unit result.
// ----------------------------------------------------------------------------
`default_nettype none

package pas_pkg;

  // Command codes carried on the command beat
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_RAN      = 3'd2,
    ST_FINISHED = 3'd3,
    ST_IDLE     = 3'd4
  } status_t;

  localparam logic signed [15:0] PRIO_FLOOR = 16'sh8000;

  typedef struct packed {
    logic [7:0]         id;
    logic signed [15:0] prio;
    logic [15:0]        total;
    logic [15:0]        used;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Result of the shared slot unit
  typedef struct packed {
    logic [15:0]        used_next;
    logic [15:0]        remain;
    logic               finished;
    logic signed [15:0] prio_dec;
    logic               lt;
  } alu_out_t;

endpackage

`default_nettype wire

// ===== sv/pas_cmd_if.sv =====
// ----------------------------------------------------------------------------
// pas_cmd_if: command channel
// Valid/ready channel carrying one scheduler command per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pas_cmd_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [7:0]         job_id;
  logic signed [7:0]  job_priority;
  logic [15:0]        job_run_time;

  modport source (output valid, command, job_id, job_priority, job_run_time,
                  input ready);
  modport sink   (input valid, command, job_id, job_priority, job_run_time,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/pas_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pas_rsp_if: result channel
// Valid/ready channel carrying one scheduler result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pas_rsp_if #(
  parameter int CNT_W = 5
);
  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic [7:0]       ran_id;
  logic [15:0]      used_time;
  logic [15:0]      remaining_time;
  logic [31:0]      slice_number;
  logic [CNT_W-1:0] queue_count;
  logic             all_done;

  modport source (output valid, status, ran_id, used_time, remaining_time,
                  slice_number, queue_count, all_done, input ready);
  modport sink   (input valid, status, ran_id, used_time, remaining_time,
                  slice_number, queue_count, all_done, output ready);
endinterface

`default_nettype wire

// ===== sv/pas_ram.sv =====
// ----------------------------------------------------------------------------
// pas_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/pas_alu.sv =====
// ----------------------------------------------------------------------------
// pas_alu: shared slot unit
// Advance a slot's used time, age its priority and compare priorities.
// ----------------------------------------------------------------------------
`default_nettype none

module pas_alu
  import pas_pkg::*;
(
  input  wire entry_t             slot,
  input  wire logic signed [15:0] ins_prio,
  output alu_out_t                res
);

  logic [15:0] used_next;

  assign used_next = slot.used + 16'd1;

  always_comb begin
    res.used_next = used_next;
    res.finished  = (used_next >= slot.total);
    res.remain    = (slot.total > used_next) ? (slot.total - used_next) : 16'd0;
    // saturate the aging drop at the floor
    res.prio_dec  = (slot.prio == PRIO_FLOOR) ? slot.prio : (slot.prio - 16'sd1);
    res.lt        = ($signed(slot.prio) < $signed(ins_prio));
  end

endmodule

`default_nettype wire

// ===== sv/priority_aging_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_aging_scheduler: dynamic priority job scheduler with aging
// Ready table kept sorted in a circular buffer RAM, insertion walk from tail.
// ----------------------------------------------------------------------------
// Flow: an add goes S_INS_START, S_INS_CMP past lower-priority entries (S_INS_PUT
//   if the walk reaches the head), S_RESP; a tick pops in S_TK_EXE, then finishes
//   to S_RESP or reinserts by the same walk; a full add or idle tick goes to S_RESP.
// Throughput: one command at a time; the insertion walk moves one table slot
//   per cycle through the single RAM read and write port, so MAX_PROCS bounds
//   the walk. A new command is taken while the previous result is waiting.
// Reset: occupancy, pointers and slice counter clear; table RAM is not cleared.
`default_nettype none

module priority_aging_scheduler
  import pas_pkg::*;
#(
  parameter int MAX_PROCS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  pas_cmd_if.sink   cmd,
  pas_rsp_if.source rsp
);

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TK_EXE,
    S_INS_START,
    S_INS_CMP,
    S_INS_PUT,
    S_RESP
  } state_t;

  // Circular index helpers
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(MAX_PROCS - 1)) ? '0 : (p + IDX_W'(1));
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] p);
    return (p == '0) ? IDX_W'(MAX_PROCS - 1) : (p - IDX_W'(1));
  endfunction

  state_t           state;
  logic [IDX_W-1:0] head;       // oldest slot: highest priority
  logic [IDX_W-1:0] tail;       // first free slot
  logic [CNT_W-1:0] occ;        // jobs in table
  logic [31:0]      slice;      // slices executed
  logic [IDX_W-1:0] wr_ptr;     // hole being moved down by the walk
  logic [CNT_W-1:0] cnt;        // entries still ahead of the hole
  entry_t           ins_entry;  // job being placed

  // Pending result fields
  status_t          res_status;
  logic [7:0]       res_id;
  logic [15:0]      res_used;
  logic [15:0]      res_remain;
  logic             res_done;

  // Output register
  logic             out_valid;
  status_t          out_status;
  logic [7:0]       out_id;
  logic [15:0]      out_used;
  logic [15:0]      out_remain;
  logic [31:0]      out_slice;
  logic [CNT_W-1:0] out_count;
  logic             out_done;

  // RAM port
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t           rd_entry;
  alu_out_t         alu;

  logic             cmd_beat;
  logic             out_free;

  assign rd_entry  = entry_t'(ram_rdata);
  assign cmd.ready = (state == S_IDLE);
  assign cmd_beat  = cmd.valid && cmd.ready;
  assign out_free  = !out_valid || rsp.ready;

  pas_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PROCS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pas_alu u_alu (
    .slot     (rd_entry),
    .ins_prio (ins_entry.prio),
    .res      (alu)
  );

  // RAM port steering: the walk reads one slot ahead of the hole while
  // the slot just compared drops into the hole.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_ptr;
    ram_wdata = ins_entry;
    ram_raddr = head;
    case (state)
      S_IDLE: begin
        ram_raddr = head;
      end
      S_INS_START: begin
        if (cnt == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_raddr = idx_dec(wr_ptr);
        end
      end
      S_INS_CMP: begin
        ram_we = 1'b1;
        if (alu.lt) begin
          ram_wdata = rd_entry;
          if (cnt != CNT_W'(1)) begin
            ram_raddr = idx_dec(idx_dec(wr_ptr));
          end
        end
      end
      S_INS_PUT: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      occ       <= '0;
      slice     <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drain the output register on a taken beat; S_RESP reloads it itself
      if (out_valid && rsp.ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_beat) begin
            res_id     <= '0;
            res_used   <= '0;
            res_remain <= '0;
            res_done   <= 1'b0;
            if (cmd.command == CMD_ADD) begin
              if (occ == CNT_W'(MAX_PROCS)) begin
                res_status <= ST_FULL;
                state      <= S_RESP;
              end else begin
                res_status      <= ST_ADDED;
                ins_entry.id    <= cmd.job_id;
                ins_entry.prio  <= 16'(signed'(cmd.job_priority));
                ins_entry.total <= cmd.job_run_time;
                ins_entry.used  <= '0;
                wr_ptr          <= tail;
                cnt             <= occ;
                state           <= S_INS_START;
              end
            end else if (occ == '0) begin
              res_status <= ST_IDLE;
              state      <= S_RESP;
            end else begin
              // head read already issued
              state <= S_TK_EXE;
            end
          end
        end

        S_TK_EXE: begin
          // Pop the head and run one slice
          head       <= idx_inc(head);
          occ        <= occ - CNT_W'(1);
          slice      <= slice + 32'd1;
          res_id     <= rd_entry.id;
          res_used   <= alu.used_next;
          res_remain <= alu.remain;
          if (alu.finished) begin
            res_status <= ST_FINISHED;
            res_done   <= (occ == CNT_W'(1));
            state      <= S_RESP;
          end else begin
            res_status      <= ST_RAN;
            ins_entry.id    <= rd_entry.id;
            ins_entry.prio  <= alu.prio_dec;
            ins_entry.total <= rd_entry.total;
            ins_entry.used  <= alu.used_next;
            wr_ptr          <= tail;
            cnt             <= occ - CNT_W'(1);
            state           <= S_INS_START;
          end
        end

        S_INS_START: begin
          if (cnt == '0) begin
            occ   <= occ + CNT_W'(1);
            tail  <= idx_inc(tail);
            state <= S_RESP;
          end else begin
            state <= S_INS_CMP;
          end
        end

        S_INS_CMP: begin
          if (alu.lt) begin
            // Shift the lower-priority entry down, advance the hole
            wr_ptr <= idx_dec(wr_ptr);
            cnt    <= cnt - CNT_W'(1);
            if (cnt == CNT_W'(1)) begin
              state <= S_INS_PUT;
            end
          end else begin
            occ   <= occ + CNT_W'(1);
            tail  <= idx_inc(tail);
            state <= S_RESP;
          end
        end

        S_INS_PUT: begin
          occ   <= occ + CNT_W'(1);
          tail  <= idx_inc(tail);
          state <= S_RESP;
        end

        S_RESP: begin
          // Hold until the output register has room
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_id     <= res_id;
            out_used   <= res_used;
            out_remain <= res_remain;
            out_slice  <= slice;
            out_count  <= occ;
            out_done   <= res_done;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.ran_id         = out_id;
  assign rsp.used_time      = out_used;
  assign rsp.remaining_time = out_remain;
  assign rsp.slice_number   = out_slice;
  assign rsp.queue_count    = out_count;
  assign rsp.all_done       = out_done;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(MAX_PROCS))
    else $error("occupancy above table depth");

  a_walk_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_CMP) |-> ((cnt != '0) && (cnt <= occ)))
    else $error("insertion walk count out of range");

  a_all_done_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.all_done) |->
      ((rsp.queue_count == '0) && (rsp.status == ST_FINISHED)))
    else $error("all_done with jobs left or wrong status");

  a_slice_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (slice != $past(slice))) |-> (slice == $past(slice) + 32'd1))
    else $error("slice counter jumped");

  a_tail_track: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |->
      (((32'(head) + 32'(occ)) >= 32'(MAX_PROCS)) ?
        (32'(tail) == 32'(head) + 32'(occ) - 32'(MAX_PROCS)) :
        (32'(tail) == 32'(head) + 32'(occ))))
    else $error("tail pointer out of step with head and occupancy");
`endif

endmodule

`default_nettype wire
